@@ src/gmds_pkg.sv @@
// Package for the grid maze depth-first solver.
// Holds sizes, register indexes, direction codes, queue and state types.
// No dependencies.
package gmds_pkg;

  localparam int MAX_WIDTH  = 8;
  localparam int MAX_HEIGHT = 8;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int LI_W       = CELL_W + 1;
  localparam int XW         = 3;
  localparam int DW         = 4;

  typedef enum logic [2:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_START_X     = 3'd2,
    CFG_START_Y     = 3'd3,
    CFG_END_X       = 3'd4,
    CFG_END_Y       = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_EAST  = 2'd2,
    DIR_WEST  = 2'd3
  } dir_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_START,
    BK_START_CHK,
    BK_PROBE,
    BK_CHECK,
    BK_POP,
    BK_EMIT_RD,
    BK_EMIT_WR,
    BK_SINGLE
  } back_state_e;

  // Effective dimensions and endpoints
  typedef struct packed {
    logic [DW-1:0] width;
    logic [DW-1:0] height;
    logic [XW-1:0] start_x;
    logic [XW-1:0] start_y;
    logic [XW-1:0] end_x;
    logic [XW-1:0] end_y;
  } cfg_t;

  // One classified cell on its way to the back end
  typedef struct packed {
    logic              wall;
    logic              keep;
    logic [CELL_W-1:0] addr;
    logic              last;
  } cell_cmd_t;

  function automatic logic [CELL_W-1:0] cell_idx(input logic [XW-1:0] x,
                                                 input logic [XW-1:0] y);
    return CELL_W'(CELL_W'(y) * CELL_W'(MAX_WIDTH) + CELL_W'(x));
  endfunction

endpackage

@@ src/grid_maze_dfs_solver_core.sv @@
// Top level of the grid maze depth-first solver: config registers, front, queue, back.
// Depends on gmds_pkg, gmds_front, gmds_queue, gmds_back.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   cell    | in        | in_valid_i/in_ready_o | wall_i, last_cell_i
//   config  | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   path    | out       | out_valid_o/out_ready_i | move_dir_o, found_o, no_move_o, last_step_o
//
// Cells load one per cycle while the back end is idle, through a two-entry queue
// into the wall map; storing a cell also clears its visited bit. After the last
// cell: start, start check, probe and check per trial, pop per dropped frame,
// each on a registered read; a path step is a stack read, then an output write.
// The queue fills and in_ready_o drops while a search or path stream is running.
// Reset restores width 8, height 8, start (0,0) and goal (7,7); no clearing pass.
module grid_maze_dfs_solver_core import gmds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       wall_i,
  input  logic       last_cell_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [3:0] cfg_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] move_dir_o,
  output logic       found_o,
  output logic       no_move_o,
  output logic       last_step_o
);

  logic [3:0]    gw_q, gh_q;
  logic [XW-1:0] sx_q, sy_q, ex_q, ey_q;
  cfg_t          cfg;
  cell_cmd_t     front_cmd, back_cmd;
  logic          q_full, q_valid, q_pop, push;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full;
  assign push        = in_valid_i && !q_full;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= 4'd8;
      gh_q <= 4'd8;
      sx_q <= '0;
      sy_q <= '0;
      ex_q <= 3'd7;
      ey_q <= 3'd7;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_WIDTH:  gw_q <= cfg_data_i;
        CFG_GRID_HEIGHT: gh_q <= cfg_data_i;
        CFG_START_X:     sx_q <= cfg_data_i[XW-1:0];
        CFG_START_Y:     sy_q <= cfg_data_i[XW-1:0];
        CFG_END_X:       ex_q <= cfg_data_i[XW-1:0];
        CFG_END_Y:       ey_q <= cfg_data_i[XW-1:0];
        default:         gw_q <= gw_q;
      endcase
    end
  end

  // Clamp dimensions to the map size
  always_comb begin
    cfg.width   = (gw_q < DW'(MAX_WIDTH))  ? gw_q : DW'(MAX_WIDTH);
    cfg.height  = (gh_q < DW'(MAX_HEIGHT)) ? gh_q : DW'(MAX_HEIGHT);
    cfg.start_x = sx_q;
    cfg.start_y = sy_q;
    cfg.end_x   = ex_q;
    cfg.end_y   = ey_q;
  end

  gmds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push_i      (push),
    .wall_i      (wall_i),
    .last_cell_i (last_cell_i),
    .cmd_o       (front_cmd)
  );

  gmds_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (back_cmd)
  );

  gmds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (q_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .move_dir_o  (move_dir_o),
    .found_o     (found_o),
    .no_move_o   (no_move_o),
    .last_step_o (last_step_o)
  );

endmodule

@@ src/gmds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gmds_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/gmds_front.sv @@
// Front end: counts loaded cells and maps each to a wall map address.
// Depends on gmds_pkg.
module gmds_front import gmds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      push_i,
  input  logic      wall_i,
  input  logic      last_cell_i,
  output cell_cmd_t cmd_o
);

  logic [LI_W-1:0] li_q, li_d;
  logic [LI_W-1:0] row_q, row_d;
  logic [DW-1:0]   col_q, col_d;
  logic            in_range;

  assign in_range = (li_q < LI_W'(CELLS)) && (cfg_i.width != '0)
                    && (row_q < LI_W'(cfg_i.height));

  always_comb begin
    cmd_o.wall = wall_i;
    cmd_o.keep = in_range;
    cmd_o.addr = cell_idx(col_q[XW-1:0], row_q[XW-1:0]);
    cmd_o.last = last_cell_i;
  end

  // Advance the load index with its row and column, restart after the last cell
  always_comb begin
    li_d  = li_q;
    row_d = row_q;
    col_d = col_q;
    if (push_i) begin
      if (last_cell_i) begin
        li_d  = '0;
        row_d = '0;
        col_d = '0;
      end else if (li_q < LI_W'(CELLS)) begin
        li_d = li_q + 1'b1;
        if (col_q + 1'b1 == cfg_i.width) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      li_q  <= '0;
      row_q <= '0;
      col_q <= '0;
    end else begin
      li_q  <= li_d;
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

@@ src/gmds_queue.sv @@
// Two-entry queue of classified cells between front and back end.
// Depends on gmds_pkg.
module gmds_queue import gmds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cell_cmd_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output cell_cmd_t data_o
);

  cell_cmd_t  ent_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rptr_q];

  // Update pointers and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= data_i;
    end
  end

endmodule

@@ src/gmds_back.sv @@
// Back end: writes the wall map, runs the depth-first search, streams the path.
// Depends on gmds_pkg and gmds_ram.
module gmds_back import gmds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cell_cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic [1:0] move_dir_o,
  output logic      found_o,
  output logic      no_move_o,
  output logic      last_step_o
);

  back_state_e state_q, state_d;

  logic [XW-1:0]     cur_x_q, cur_y_q;
  logic [XW:0]       nx_q, ny_q;
  logic [XW:0]       nx, ny;
  logic [CELL_W-1:0] depth_q;
  logic [CELL_W-1:0] k_q;
  logic [1:0]        trial_q;
  logic              single_found_q;

  logic              out_valid_q;
  logic [1:0]        out_dir_q;
  logic              out_found_q, out_nm_q, out_last_q;

  // Map entry: bit 1 wall, bit 0 visited
  logic              map_we;
  logic [CELL_W-1:0] map_waddr, map_raddr;
  logic [1:0]        map_wdata, map_rd;
  logic              stk_we;
  logic [CELL_W-1:0] stk_raddr;
  logic [1:0]        stk_rd;

  logic              out_free;
  logic              next_end, next_ok, start_end, start_ok;
  logic [CELL_W-1:0] next_idx;
  logic              out_load;

  assign out_free = !out_valid_q || out_ready_i;

  // Neighbor of the current cell in the trial direction
  always_comb begin
    nx = {1'b0, cur_x_q};
    ny = {1'b0, cur_y_q};
    case (dir_e'(trial_q))
      DIR_NORTH: ny = {1'b0, cur_y_q} - 1'b1;
      DIR_SOUTH: ny = {1'b0, cur_y_q} + 1'b1;
      DIR_EAST:  nx = {1'b0, cur_x_q} + 1'b1;
      DIR_WEST:  nx = {1'b0, cur_x_q} - 1'b1;
      default:   nx = {1'b0, cur_x_q};
    endcase
  end

  assign next_end  = (nx == {1'b0, cfg_i.end_x}) && (ny == {1'b0, cfg_i.end_y});
  assign start_end = (cfg_i.start_x == cfg_i.end_x) && (cfg_i.start_y == cfg_i.end_y);
  assign next_idx  = cell_idx(nx_q[XW-1:0], ny_q[XW-1:0]);
  assign next_ok   = (DW'(nx_q) < cfg_i.width) && (DW'(ny_q) < cfg_i.height)
                     && !map_rd[1] && !map_rd[0] && (depth_q != CELL_W'(CELLS - 1));
  assign start_ok  = (DW'(cfg_i.start_x) < cfg_i.width)
                     && (DW'(cfg_i.start_y) < cfg_i.height) && !map_rd[1];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && cmd_i.last) state_d = BK_START;
      end
      BK_START: begin
        state_d = start_end ? BK_SINGLE : BK_START_CHK;
      end
      BK_START_CHK: begin
        state_d = start_ok ? BK_PROBE : BK_SINGLE;
      end
      BK_PROBE: begin
        state_d = next_end ? BK_EMIT_RD : BK_CHECK;
      end
      BK_CHECK: begin
        if (next_ok || trial_q != 2'd3) begin
          state_d = BK_PROBE;
        end else if (depth_q == '0) begin
          state_d = BK_SINGLE;
        end else begin
          state_d = BK_POP;
        end
      end
      BK_POP: begin
        if (stk_rd != 2'd3) begin
          state_d = BK_PROBE;
        end else if (depth_q == '0) begin
          state_d = BK_SINGLE;
        end
      end
      BK_EMIT_RD: begin
        state_d = BK_EMIT_WR;
      end
      BK_EMIT_WR: begin
        if (out_free) state_d = (k_q == depth_q) ? BK_IDLE : BK_EMIT_RD;
      end
      BK_SINGLE: begin
        if (out_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Memory controls and queue pop; storing a cell also clears its visited bit
  always_comb begin
    cmd_pop_o = 1'b0;
    map_we    = 1'b0;
    map_waddr = cmd_i.addr;
    map_wdata = {cmd_i.wall, 1'b0};
    map_raddr = cell_idx(nx[XW-1:0], ny[XW-1:0]);
    stk_we    = 1'b0;
    out_load  = 1'b0;
    stk_raddr = k_q;
    case (state_q)
      BK_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        map_we    = cmd_valid_i && cmd_i.keep;
      end
      BK_START: map_raddr = cell_idx(cfg_i.start_x, cfg_i.start_y);
      BK_START_CHK: begin
        // Mark the start cell visited, it is open
        map_we    = start_ok;
        map_waddr = cell_idx(cfg_i.start_x, cfg_i.start_y);
        map_wdata = {1'b0, 1'b1};
      end
      BK_PROBE: stk_we = 1'b1;
      BK_CHECK: begin
        stk_raddr = depth_q - 1'b1;
        map_we    = next_ok;
        map_waddr = next_idx;
        map_wdata = {1'b0, 1'b1};
      end
      BK_POP:   stk_raddr = depth_q - 1'b1;
      BK_EMIT_WR, BK_SINGLE: out_load = out_free;
      default: cmd_pop_o = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      depth_q     <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BK_START_CHK: begin
          depth_q <= '0;
          cur_x_q <= cfg_i.start_x;
          cur_y_q <= cfg_i.start_y;
        end
        BK_CHECK: begin
          if (next_ok) begin
            depth_q <= depth_q + 1'b1;
            cur_x_q <= nx_q[XW-1:0];
            cur_y_q <= ny_q[XW-1:0];
          end else if (trial_q == 2'd3 && depth_q != '0) begin
            depth_q <= depth_q - 1'b1;
          end
        end
        BK_POP: begin
          // Undo the move that led into the dropped frame
          case (dir_e'(stk_rd))
            DIR_NORTH: cur_y_q <= cur_y_q + 1'b1;
            DIR_SOUTH: cur_y_q <= cur_y_q - 1'b1;
            DIR_EAST:  cur_x_q <= cur_x_q - 1'b1;
            DIR_WEST:  cur_x_q <= cur_x_q + 1'b1;
            default:   cur_x_q <= cur_x_q;
          endcase
          if (stk_rd == 2'd3 && depth_q != '0) depth_q <= depth_q - 1'b1;
        end
        default: depth_q <= depth_q;
      endcase
    end
  end

  // Search datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_START: begin
        single_found_q <= start_end;
      end
      BK_START_CHK: begin
        trial_q        <= '0;
        single_found_q <= 1'b0;
      end
      BK_PROBE: begin
        nx_q <= nx;
        ny_q <= ny;
        k_q  <= '0;
      end
      BK_CHECK: begin
        if (next_ok) begin
          trial_q <= '0;
        end else if (trial_q != 2'd3) begin
          trial_q <= trial_q + 1'b1;
        end
      end
      BK_POP: begin
        if (stk_rd != 2'd3) trial_q <= stk_rd + 1'b1;
      end
      BK_EMIT_WR: begin
        if (out_free) k_q <= k_q + 1'b1;
      end
      default: trial_q <= trial_q;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == BK_SINGLE) begin
        out_dir_q   <= DIR_NORTH;
        out_found_q <= single_found_q;
        out_nm_q    <= 1'b1;
        out_last_q  <= 1'b1;
      end else begin
        out_dir_q   <= stk_rd;
        out_found_q <= 1'b1;
        out_nm_q    <= 1'b0;
        out_last_q  <= (k_q == depth_q);
      end
    end
  end

  gmds_ram #(.WIDTH(2), .DEPTH(CELLS)) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rd)
  );

  gmds_ram #(.WIDTH(2), .DEPTH(CELLS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (depth_q),
    .wdata_i (trial_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rd)
  );

  assign out_valid_o = out_valid_q;
  assign move_dir_o  = out_dir_q;
  assign found_o     = out_found_q;
  assign no_move_o   = out_nm_q;
  assign last_step_o = out_last_q;

endmodule

@@ src/gmds_checker.sv @@
// Port-level checks on the solver's result stream, bound to the top level.
// Depends on grid_maze_dfs_solver_core.
module gmds_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] move_dir_o,
  input logic       found_o,
  input logic       no_move_o,
  input logic       last_step_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A result without a step closes the run
  a_nomove_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_move_o |-> last_step_o && move_dir_o == 2'd0)
    else $error("no-move result malformed");

  // Not found carries no step
  a_notfound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> no_move_o)
    else $error("not-found result carries a step");

  // A path step that is not the last is followed by another step
  a_path_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_step_o |=> !(out_valid_o && no_move_o))
    else $error("path broken off");

endmodule

bind grid_maze_dfs_solver_core gmds_checker u_gmds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .move_dir_o  (move_dir_o),
  .found_o     (found_o),
  .no_move_o   (no_move_o),
  .last_step_o (last_step_o)
);
